FILE: sv/rmsp_pkg.sv
`timescale 1ns / 1ps

package rmsp_pkg;

	// Storage and field widths
	localparam int PARAM_COUNT = 65536;
	localparam int IDX_W       = 16;
	localparam int MEAN_W      = 48;
	localparam int ROOT_W      = MEAN_W / 2;
	localparam int NUM_W       = 48;
	localparam int ADDR_W      = 4;

	// eps of 1e-8 in Q16.32
	localparam logic [MEAN_W-1:0] EPS_Q32 = 48'd43;

	// Register reset values
	localparam logic [23:0] LEARN_RATE_RST   = 24'd16777;
	localparam logic [15:0] DECAY_BETA_RST   = 16'd58982;
	localparam logic [16:0] WEIGHT_SCALE_RST = 17'd65536;

	typedef enum logic [1:0] {
		REG_LEARN_RATE   = 2'd0,
		REG_DECAY_BETA   = 2'd1,
		REG_WEIGHT_SCALE = 2'd2,
		REG_NONE         = 2'd3
	} reg_idx_t;

	// Request data carried alongside the root and divide pipelines
	typedef struct packed {
		logic                    neg;
		logic signed [32:0]      base;
		logic [NUM_W-1:0]        num;
	} upd_side_t;

	// Mean store write port
	typedef struct packed {
		logic               en;
		logic [IDX_W-1:0]   addr;
		logic [MEAN_W-1:0]  data;
	} mean_wr_t;

endpackage

FILE: sv/rmsp_mem.sv
`timescale 1ns / 1ps

module rmsp_mem import rmsp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [IDX_W-1:0]  rd_addr,
	output logic [MEAN_W-1:0] rd_data,
	input  mean_wr_t          wr,
	output logic              busy
);

	logic [MEAN_W-1:0] mem [PARAM_COUNT];
	logic              clr_q;
	logic [IDX_W-1:0]  clr_idx_q;

	// Clearing pass after reset, one entry a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
		end else if (clr_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == IDX_W'(PARAM_COUNT - 1))
				clr_q <= 1'b0;
		end
	end

	// Single write port, registered read (old data on a same-address collision)
	always_ff @(posedge clk) begin
		if (clr_q)
			mem[clr_idx_q] <= '0;
		else if (wr.en)
			mem[wr.addr] <= wr.data;
		if (rd_en)
			rd_data <= mem[rd_addr];
	end

	assign busy = clr_q;

endmodule

FILE: sv/rmsp_sqrt.sv
`timescale 1ns / 1ps

module rmsp_sqrt import rmsp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  logic [MEAN_W-1:0] rad,
	input  upd_side_t         side_in,
	output logic              out_vld,
	output logic [ROOT_W-1:0] root,
	output upd_side_t         side_out
);

	logic              stg_vld_q [ROOT_W];
	logic [MEAN_W-1:0] stg_x_q   [ROOT_W];
	logic [ROOT_W+1:0] stg_rem_q [ROOT_W];
	logic [ROOT_W-1:0] stg_rt_q  [ROOT_W];
	upd_side_t         stg_sd_q  [ROOT_W];

	// One root bit per stage, restoring digit recurrence
	for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
		logic              p_vld;
		logic [MEAN_W-1:0] p_x;
		logic [ROOT_W+1:0] p_rem;
		logic [ROOT_W-1:0] p_rt;
		upd_side_t         p_sd;
		logic [ROOT_W+3:0] shf;
		logic [ROOT_W+3:0] trial;
		logic [ROOT_W+3:0] diff;
		logic              fits;

		if (i == 0) begin : g_first
			assign p_vld = in_vld;
			assign p_x   = rad;
			assign p_rem = '0;
			assign p_rt  = '0;
			assign p_sd  = side_in;
		end else begin : g_next
			assign p_vld = stg_vld_q[i-1];
			assign p_x   = stg_x_q[i-1];
			assign p_rem = stg_rem_q[i-1];
			assign p_rt  = stg_rt_q[i-1];
			assign p_sd  = stg_sd_q[i-1];
		end

		assign shf   = {p_rem, p_x[MEAN_W-1 -: 2]};
		assign trial = {2'b00, p_rt, 2'b01};
		assign diff  = shf - trial;
		assign fits  = shf >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				stg_vld_q[i] <= 1'b0;
			else if (en)
				stg_vld_q[i] <= p_vld;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				stg_x_q[i]   <= p_x << 2;
				stg_rem_q[i] <= fits ? diff[ROOT_W+1:0] : shf[ROOT_W+1:0];
				stg_rt_q[i]  <= {p_rt[ROOT_W-2:0], fits};
				stg_sd_q[i]  <= p_sd;
			end
		end
	end

	assign out_vld  = stg_vld_q[ROOT_W-1];
	assign root     = stg_rt_q[ROOT_W-1];
	assign side_out = stg_sd_q[ROOT_W-1];

endmodule

FILE: sv/rmsp_div.sv
`timescale 1ns / 1ps

module rmsp_div import rmsp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  logic [ROOT_W-1:0] den,
	input  upd_side_t         side_in,
	output logic              out_vld,
	output logic [NUM_W-1:0]  quot,
	output upd_side_t         side_out
);

	logic              stg_vld_q [NUM_W];
	logic [NUM_W-1:0]  stg_n_q   [NUM_W];
	logic [ROOT_W-1:0] stg_d_q   [NUM_W];
	logic [ROOT_W-1:0] stg_rem_q [NUM_W];
	logic [NUM_W-1:0]  stg_q_q   [NUM_W];
	upd_side_t         stg_sd_q  [NUM_W];

	// One quotient bit per stage, restoring division
	for (genvar i = 0; i < NUM_W; i++) begin : g_stage
		logic              p_vld;
		logic [NUM_W-1:0]  p_n;
		logic [ROOT_W-1:0] p_d;
		logic [ROOT_W-1:0] p_rem;
		logic [NUM_W-1:0]  p_q;
		upd_side_t         p_sd;
		logic [ROOT_W:0]   shf;
		logic [ROOT_W:0]   diff;
		logic              fits;

		if (i == 0) begin : g_first
			assign p_vld = in_vld;
			assign p_n   = side_in.num;
			assign p_d   = den;
			assign p_rem = '0;
			assign p_q   = '0;
			assign p_sd  = side_in;
		end else begin : g_next
			assign p_vld = stg_vld_q[i-1];
			assign p_n   = stg_n_q[i-1];
			assign p_d   = stg_d_q[i-1];
			assign p_rem = stg_rem_q[i-1];
			assign p_q   = stg_q_q[i-1];
			assign p_sd  = stg_sd_q[i-1];
		end

		assign shf  = {p_rem, p_n[NUM_W-1]};
		assign diff = shf - {1'b0, p_d};
		assign fits = shf >= {1'b0, p_d};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				stg_vld_q[i] <= 1'b0;
			else if (en)
				stg_vld_q[i] <= p_vld;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				stg_n_q[i]   <= p_n << 1;
				stg_d_q[i]   <= p_d;
				stg_rem_q[i] <= fits ? diff[ROOT_W-1:0] : shf[ROOT_W-1:0];
				stg_q_q[i]   <= {p_q[NUM_W-2:0], fits};
				stg_sd_q[i]  <= p_sd;
			end
		end
	end

	assign out_vld  = stg_vld_q[NUM_W-1];
	assign quot     = stg_q_q[NUM_W-1];
	assign side_out = stg_sd_q[NUM_W-1];

endmodule

FILE: sv/rmsprop_parameter_update_unit.sv
`timescale 1ns / 1ps

// Channel   Handshake               Payload
// config    psel/penable/pwrite     paddr, pwdata -> prdata (pready tied high)
// in        in_valid / in_ready     param_index, is_weight, param_value, gradient
// out       out_valid / out_ready   new_value, saturated
//
// One request per cycle sustained while the output is not stalled and no interlock bubble
// is due; a request passes 3 update stages, 24 root stages, 48 divide stages and
// the output register to out_valid. After reset the mean store clears all 65536
// entries with in_ready low. Two requests to the same index in adjacent cycles are
// separated by a bubble (mean read-modify-write interlock); older writes are forwarded.
// An output stall freezes the whole pipeline.

module rmsprop_parameter_update_unit import rmsp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [IDX_W-1:0]   param_index,
	input  logic               is_weight,
	input  logic signed [31:0] param_value,
	input  logic signed [31:0] gradient,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] new_value,
	output logic               saturated
);

	logic [23:0] learn_rate_q;
	logic [15:0] decay_beta_q;
	logic [16:0] weight_scale_q;
	reg_idx_t    reg_sel;

	// Configuration registers
	assign reg_sel = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			learn_rate_q   <= LEARN_RATE_RST;
			decay_beta_q   <= DECAY_BETA_RST;
			weight_scale_q <= WEIGHT_SCALE_RST;
		end else if (psel && penable && pwrite) begin
			case (reg_sel)
				REG_LEARN_RATE:   learn_rate_q   <= pwdata[23:0];
				REG_DECAY_BETA:   decay_beta_q   <= pwdata[15:0];
				REG_WEIGHT_SCALE: weight_scale_q <= pwdata[16:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_LEARN_RATE:   prdata = 32'(learn_rate_q);
			REG_DECAY_BETA:   prdata = 32'(decay_beta_q);
			REG_WEIGHT_SCALE: prdata = 32'(weight_scale_q);
			default:          prdata = '0;
		endcase
	end

	// Pipeline control
	logic adv, hazard, s1_adv, acc, mem_busy;
	logic out_vld_q;

	logic              s1_vld, s1_inr, s1_isw, s1_neg;
	logic [IDX_W-1:0]  s1_idx;
	logic [31:0]       s1_w, s1_gmag;
	logic [MEAN_W-1:0] s1_gsq;

	logic              s2_vld, s2_inr, s2_isw, s2_neg;
	logic [IDX_W-1:0]  s2_idx;
	logic [31:0]       s2_w;
	logic [63:0]       s2_pv;
	logic [64:0]       s2_pg;
	logic [48:0]       s2_pw;
	logic [55:0]       s2_pn;

	logic              s3_vld, s3_inr;
	logic [IDX_W-1:0]  s3_idx;
	logic [MEAN_W-1:0] s3_nv;
	upd_side_t         s3_sd;

	assign adv      = !out_vld_q || out_ready;
	assign hazard   = s1_vld && s2_vld && s1_inr && s2_inr && (s1_idx == s2_idx);
	assign s1_adv   = adv && !hazard;
	assign in_ready = s1_adv && !mem_busy;
	assign acc      = in_valid && in_ready;

	// Input: gradient magnitude and square
	logic [31:0] g_mag;
	logic [63:0] g_sq;
	logic        in_range;

	assign g_mag    = gradient[31] ? (~gradient + 32'd1) : gradient;
	assign g_sq     = g_mag * g_mag;
	assign in_range = ({16'd0, param_index} < 32'(PARAM_COUNT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_vld <= 1'b0;
		else if (s1_adv)
			s1_vld <= acc;
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			s1_idx  <= param_index;
			s1_inr  <= in_range;
			s1_isw  <= is_weight;
			s1_w    <= param_value;
			s1_neg  <= gradient[31];
			s1_gmag <= g_mag;
			s1_gsq  <= g_sq[63:16];
		end
	end

	// Mean store
	logic [MEAN_W-1:0] rd_data;
	mean_wr_t          wr;

	rmsp_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (acc),
		.rd_addr (param_index),
		.rd_data (rd_data),
		.wr      (wr),
		.busy    (mem_busy)
	);

	// Write history for reads that crossed a write
	logic              wr1_vld_q, wr2_vld_q;
	logic [IDX_W-1:0]  wr1_addr_q, wr2_addr_q;
	logic [MEAN_W-1:0] wr1_data_q, wr2_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr1_vld_q <= 1'b0;
			wr2_vld_q <= 1'b0;
		end else if (wr.en) begin
			wr1_vld_q <= 1'b1;
			wr2_vld_q <= wr1_vld_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			wr1_addr_q <= wr.addr;
			wr1_data_q <= wr.data;
			wr2_addr_q <= wr1_addr_q;
			wr2_data_q <= wr1_data_q;
		end
	end

	// Stage 1: forwarded mean, products
	logic [MEAN_W-1:0] v_fwd;
	logic [31:0]       w_mag;

	always_comb begin
		if (!s1_inr)
			v_fwd = '0;
		else if (s3_vld && s3_inr && (s3_idx == s1_idx))
			v_fwd = s3_nv;
		else if (wr1_vld_q && (wr1_addr_q == s1_idx))
			v_fwd = wr1_data_q;
		else if (wr2_vld_q && (wr2_addr_q == s1_idx))
			v_fwd = wr2_data_q;
		else
			v_fwd = rd_data;
	end

	assign w_mag = s1_w[31] ? (~s1_w + 32'd1) : s1_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s2_vld <= 1'b0;
		else if (adv)
			s2_vld <= s1_vld && !hazard;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s2_idx <= s1_idx;
			s2_inr <= s1_inr;
			s2_isw <= s1_isw;
			s2_w   <= s1_w;
			s2_neg <= s1_neg;
			s2_pv  <= decay_beta_q * v_fwd;
			s2_pg  <= (17'h10000 - {1'b0, decay_beta_q}) * s1_gsq;
			s2_pw  <= w_mag * weight_scale_q;
			s2_pn  <= s1_gmag * learn_rate_q;
		end
	end

	// Stage 2: new mean, weight base
	logic [64:0]        mean_sum;
	logic [31:0]        w_sc;
	logic signed [32:0] base;

	assign mean_sum = {1'b0, s2_pv} + s2_pg;
	assign w_sc     = s2_pw[47:16];

	always_comb begin
		if (!s2_isw)
			base = $signed({s2_w[31], s2_w});
		else if (s2_w[31])
			base = -$signed({1'b0, w_sc});
		else
			base = $signed({1'b0, w_sc});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s3_vld <= 1'b0;
		else if (adv)
			s3_vld <= s2_vld;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s3_idx      <= s2_idx;
			s3_inr      <= s2_inr;
			s3_nv       <= mean_sum[63:16];
			s3_sd.neg   <= s2_neg;
			s3_sd.base  <= base;
			s3_sd.num   <= s2_pn[55:8];
		end
	end

	// Stage 3: write back, once as the request leaves
	assign wr = '{en: s3_vld && s3_inr && adv, addr: s3_idx, data: s3_nv};

	// Root and divide pipelines
	logic              rt_vld, dv_vld;
	logic [ROOT_W-1:0] rt;
	upd_side_t         rt_sd, dv_sd;
	logic [NUM_W-1:0]  quot;

	rmsp_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_vld   (s3_vld),
		.rad      (s3_nv + EPS_Q32),
		.side_in  (s3_sd),
		.out_vld  (rt_vld),
		.root     (rt),
		.side_out (rt_sd)
	);

	rmsp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_vld   (rt_vld),
		.den      (rt),
		.side_in  (rt_sd),
		.out_vld  (dv_vld),
		.quot     (quot),
		.side_out (dv_sd)
	);

	// Final: apply step, saturate
	logic signed [49:0] res;
	logic signed [49:0] q_ext;
	logic               sat_hi, sat_lo;
	logic signed [31:0] new_value_q;
	logic               saturated_q;

	assign q_ext  = $signed({2'b00, quot});
	assign res    = dv_sd.neg ? (50'(dv_sd.base) + q_ext) : (50'(dv_sd.base) - q_ext);
	assign sat_hi = res > 50'sh7FFFFFFF;
	assign sat_lo = res < -50'sh80000000;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (adv)
			out_vld_q <= dv_vld;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (sat_hi)
				new_value_q <= 32'sh7FFFFFFF;
			else if (sat_lo)
				new_value_q <= 32'sh80000000;
			else
				new_value_q <= res[31:0];
			saturated_q <= sat_hi || sat_lo;
		end
	end

	assign out_valid = out_vld_q;
	assign new_value = new_value_q;
	assign saturated = saturated_q;

`ifndef NO_ASSERTIONS
	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		mem_busy |-> !in_ready) else $error("request taken during clearing pass");
	a_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && hazard) |=> !s2_vld) else $error("same-index interlock missed bubble");
	a_no_wr_busy: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> !mem_busy) else $error("mean write during clearing pass");
`endif

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps

import rmsp_pkg::*;

typedef struct {
	logic signed [31:0] value;
	logic               sat;
} upd_result_t;

// Running-mean predictor and queue of expected updates
class rmsprop_scoreboard;
	bit [23:0]       lr;
	bit [15:0]       beta;
	bit [16:0]       wscale;
	bit [47:0]       mean_sq [PARAM_COUNT];
	upd_result_t     expected_q[$];
	int              errors;

	function new();
		lr     = LEARN_RATE_RST;
		beta   = DECAY_BETA_RST;
		wscale = WEIGHT_SCALE_RST;
		foreach (mean_sq[i]) mean_sq[i] = '0;
		errors = 0;
	endfunction

	function void write_reg(reg_idx_t r, bit [31:0] d);
		case (r)
			REG_LEARN_RATE:   lr = d[23:0];
			REG_DECAY_BETA:   beta = d[15:0];
			REG_WEIGHT_SCALE: wscale = d[16:0];
			default: ;
		endcase
	endfunction

	// Floor square root, one result bit at a time
	function bit [63:0] isqrt(bit [63:0] x);
		bit [63:0] r;
		bit [63:0] t;
		r = 0;
		for (int b = 25; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= x) r = t;
		end
		return r;
	endfunction

	// Accepted request: advance the mean and queue the expected value
	function void note_request(bit [15:0] idx, bit isw, logic signed [31:0] w,
		logic signed [31:0] g);
		bit [63:0]   mg, mw, gsq, nv, s, step_mag, sc;
		longint      step, base, res;
		upd_result_t e;
		mg  = (g < 0) ? 64'(-longint'(g)) : 64'(longint'(g));
		gsq = (mg * mg) >> 16;
		nv  = (64'(beta) * mean_sq[idx] + (64'd65536 - beta) * gsq) >> 16;
		mean_sq[idx] = nv[47:0];
		s        = isqrt({16'd0, nv[47:0]} + 64'd43);
		step_mag = (mg * lr) / (s * 256);
		step     = (g < 0) ? -longint'(step_mag) : longint'(step_mag);
		base     = w;
		if (isw) begin
			mw   = (w < 0) ? 64'(-longint'(w)) : 64'(longint'(w));
			sc   = (mw * wscale) >> 16;
			base = (w < 0) ? -longint'(sc) : longint'(sc);
		end
		res   = base - step;
		e.sat = 1'b0;
		if (res > 64'sh7FFFFFFF) begin
			res   = 64'sh7FFFFFFF;
			e.sat = 1'b1;
		end else if (res < -64'sh80000000) begin
			res   = -64'sh80000000;
			e.sat = 1'b1;
		end
		e.value = res[31:0];
		expected_q.insert(expected_q.size(), e);
	endfunction

	function void report(string msg);
		$display("MISMATCH: %s", msg);
		errors++;
	endfunction

	function void check_result(logic signed [31:0] v, logic sat);
		upd_result_t e;
		if (expected_q.size() == 0) begin
			report($sformatf("unexpected result value=%h sat=%b", v, sat));
			return;
		end
		e = expected_q.pop_front();
		if (v !== e.value)
			report($sformatf("new_value %h, expected %h", v, e.value));
		if (sat !== e.sat)
			report($sformatf("saturated %b, expected %b", sat, e.sat));
	endfunction

	function int pending();
		return expected_q.size();
	endfunction
endclass

module tb;
	localparam int LIMIT = 3000000;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               psel = 0, penable = 0, pwrite = 0;
	logic [ADDR_W-1:0]  paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid = 0;
	logic               in_ready;
	logic [IDX_W-1:0]   param_index = '0;
	logic               is_weight = 0;
	logic signed [31:0] param_value = '0;
	logic signed [31:0] gradient = '0;
	logic               out_valid;
	logic               out_ready = 0;
	logic signed [31:0] new_value;
	logic               saturated;

	rmsprop_scoreboard sb = new();
	int  cycles = 0;
	bit  calm = 0;
	bit  hold_req = 0;
	int  hold_left = 0;

	rmsprop_parameter_update_unit uut (.*);

	always #5 clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	// Receiver: random stalls, one long hold-off on request
	always @(posedge clk) begin
		if (hold_req && hold_left == 0) begin
			hold_left <= 400;
			hold_req  <= 0;
			out_ready <= 0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 0;
		end else begin
			out_ready <= calm || ($urandom_range(99) >= 23);
		end
	end

	// Result check
	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			sb.check_result(new_value, saturated);

	task automatic reg_write(reg_idx_t r, logic [31:0] d);
		@(posedge clk);
		psel    <= 1;
		penable <= 0;
		pwrite  <= 1;
		paddr   <= ADDR_W'({r, 2'b00});
		pwdata  <= d;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel    <= 0;
		penable <= 0;
		sb.write_reg(r, d);
	endtask

	task automatic send(bit [15:0] idx, bit isw, logic signed [31:0] w,
		logic signed [31:0] g);
		while (!calm && $urandom_range(99) < 23) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid    <= 1;
		param_index <= idx;
		is_weight   <= isw;
		param_value <= w;
		gradient    <= g;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_request(idx, isw, w, g);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending() > 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	function automatic logic signed [31:0] rand_grad();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $signed($urandom_range(65535)) - 32768;
			default: return $signed($urandom_range(33554431)) - 16777216;
		endcase
	endfunction

	initial begin
		logic [31:0] lr_set[8]   = '{16777, 24'hFFFFFF, 0, 1000, 16777, 300000, 16777, 5};
		logic [31:0] beta_set[8] = '{58982, 0, 16'hFFFF, 32768, 1, 58982, 65000, 16'hFFFF};
		logic [31:0] ws_set[8]   = '{65536, 17'h1FFFF, 0, 65000, 65536, 1, 70000, 65536};
		repeat (12) @(posedge clk);
		arst_n <= 1;

		// Directed: extremes, both kinds, back-to-back same index
		send(0, 0, 0, 0);
		send(16'hFFFF, 1, 32'sh7FFFFFFF, 32'sh80000000);
		send(16'hFFFF, 1, 32'sh80000000, 32'sh7FFFFFFF);
		send(16'hFFFF, 0, 32'sh7FFFFFFF, 32'sh80000000);
		send(1, 0, 32'sh80000000, 32'sh7FFFFFFF);
		send(1, 0, 32'sh80000000, 32'sh7FFFFFFF);
		send(1, 1, -1, -1);
		send(2, 1, 1, 1);
		send(2, 0, 32'sh01000000, 32'sh00010000);
		send(2, 0, 32'sh01000000, 0);
		send(3, 1, -32'sh01000000, -32'sh00010000);
		send(16'h8000, 1, 32'sh55555555, 32'shAAAAAAAA);
		send(16'h7FFF, 0, 32'shAAAAAAAA, 32'sh55555555);
		drain();

		// Reserved register must be ignored
		reg_write(REG_NONE, 32'hFFFFFFFF);

		// Random phases under several settings
		for (int ph = 0; ph < 8; ph++) begin
			reg_write(REG_LEARN_RATE, lr_set[ph] | ($urandom & 32'hFF000000));
			reg_write(REG_DECAY_BETA, beta_set[ph]);
			reg_write(REG_WEIGHT_SCALE, ws_set[ph]);
			calm = (ph == 2);
			if (ph == 3) hold_req = 1;
			for (int n = 0; n < 112; n++) begin
				bit [15:0] idx;
				idx = ($urandom_range(99) < 70) ? 16'($urandom_range(15)) : 16'($urandom);
				send(idx, $urandom_range(1), $urandom, rand_grad());
			end
			drain();
		end
		calm = 0;

		if (sb.errors == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end
endmodule
